/* src/xalu_pkg.sv */
// Shared operation codes, size codes and flag helpers for the x86 ALU.
`timescale 1ns / 1ps
`default_nettype none
package xalu_pkg;

  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_ADC  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_SBB  = 5'd3;
  localparam logic [4:0] OP_MUL  = 5'd4;
  localparam logic [4:0] OP_IMUL = 5'd5;
  localparam logic [4:0] OP_DIV  = 5'd6;
  localparam logic [4:0] OP_IDIV = 5'd7;
  localparam logic [4:0] OP_MOD  = 5'd8;
  localparam logic [4:0] OP_IMOD = 5'd9;
  localparam logic [4:0] OP_AND  = 5'd10;
  localparam logic [4:0] OP_XOR  = 5'd11;
  localparam logic [4:0] OP_OR   = 5'd12;
  localparam logic [4:0] OP_SHL  = 5'd13;
  localparam logic [4:0] OP_SHR  = 5'd14;
  localparam logic [4:0] OP_SAR  = 5'd15;
  localparam logic [4:0] OP_SAL  = 5'd16;

  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;

  // Flag bit positions: CF, PF, ZF, SF, OF from bit 0 up
  localparam int FL_CF = 0;
  localparam int FL_OF = 4;

  typedef logic [4:0] flags_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  // Mask for the operand size; size code three acts as 32 bits
  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    case (sz)
      SZ_8:    size_mask = 32'h0000_00FF;
      SZ_16:   size_mask = 32'h0000_FFFF;
      default: size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  // Top bit of the sized value
  function automatic logic msb_at(input logic [31:0] v, input logic [1:0] sz);
    case (sz)
      SZ_8:    msb_at = v[7];
      SZ_16:   msb_at = v[15];
      default: msb_at = v[31];
    endcase
  endfunction

  // Bit just above the operand size
  function automatic logic bit_at_n(input logic [32:0] v, input logic [1:0] sz);
    case (sz)
      SZ_8:    bit_at_n = v[8];
      SZ_16:   bit_at_n = v[16];
      default: bit_at_n = v[32];
    endcase
  endfunction

  // Operand size minus one, as a bit count
  function automatic logic [5:0] size_m1(input logic [1:0] sz);
    case (sz)
      SZ_8:    size_m1 = 6'd7;
      SZ_16:   size_m1 = 6'd15;
      default: size_m1 = 6'd31;
    endcase
  endfunction

  // Sign extend a sized value to 64 bits
  function automatic logic [63:0] sext64(input logic [31:0] v, input logic [1:0] sz);
    case (sz)
      SZ_8:    sext64 = {{56{v[7]}}, v[7:0]};
      SZ_16:   sext64 = {{48{v[15]}}, v[15:0]};
      default: sext64 = {{32{v[31]}}, v[31:0]};
    endcase
  endfunction

  // Build the flag word from a masked result
  function automatic flags_t make_flags(input logic [31:0] r, input logic [1:0] sz,
                                        input logic cf, input logic of);
    make_flags = {of, msb_at(r, sz), (r == 32'd0), ~^r[7:0], cf};
  endfunction

endpackage
`default_nettype wire

/* src/x86_alu_with_flags_core.sv */
// x86-style integer ALU with kept flags, serial multiply and divide.
// Sequence: add, sub, logic, shift and zero-divisor requests load the output
//   register in the cycle after acceptance; mul and imul step through S_RUN
//   (one multiplier bit per cycle) and then S_FIN; div, idiv, mod and imod do
//   the same (one quotient bit per cycle over the 64-bit dividend). S_FIN holds until the output register is free.
// Requests: one at a time; no new request is taken until the serial
//   shift-add/shift-subtract loop is done. Reset clears the flags, the state and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module x86_alu_with_flags_core
  import xalu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[4:0], src_operand[68:5], dest_operand[132:69], size_code[134:133]
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // result_value[63:0], carry_out[64], parity_out[65], zero_out[66],
  // negative_out[67], overflow_out[68], divide_error[69]
  output logic [71:0]       out_tdata
);

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [4:0]  mode_r, mode_nxt;
  logic [1:0]  size_r, size_nxt;
  logic        neg_q_r, neg_q_nxt, neg_m_r, neg_m_nxt;
  logic [63:0] acc_r, acc_nxt, opa_r, opa_nxt, opb_r, opb_nxt;
  logic [63:0] out_res_r, out_res_nxt;
  flags_t      flag_r, flag_nxt;
  logic        out_de_r, out_de_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [4:0]  i_mode;
  logic [63:0] i_src, i_dst;
  logic [1:0]  i_size;
  logic [31:0] m32, d32, s32;
  logic        accept, out_free, cin, is_signed, na, nb;
  logic [4:0]  cnt5;

  logic [32:0] sum33, dif33;
  logic [31:0] add_r, sub_r;
  logic [63:0] shl_t;
  logic [32:0] shr_u;
  logic [63:0] dsx64;
  logic [32:0] dsx;
  logic [33:0] sar_u;

  logic [63:0] mul_add;
  logic [64:0] div_t, div_d;
  logic        div_ge;
  logic [63:0] prod, quo, rmd, fin_val;
  logic        prod_hi;

  // Unpack the request
  assign i_mode = in_tdata[4:0];
  assign i_src  = in_tdata[68:5];
  assign i_dst  = in_tdata[132:69];
  assign i_size = in_tdata[134:133];
  assign m32    = size_mask(i_size);
  assign d32    = i_dst[31:0] & m32;
  assign s32    = i_src[31:0] & m32;
  assign cin    = flag_r[FL_CF];
  assign cnt5   = i_src[4:0];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // Add and subtract with carry or borrow at the operand size
  assign sum33 = {1'b0, d32} + {1'b0, s32} + {32'd0, (i_mode == OP_ADC) & cin};
  assign dif33 = {1'b0, d32} - {1'b0, s32} - {32'd0, (i_mode == OP_SBB) & cin};
  assign add_r = sum33[31:0] & m32;
  assign sub_r = dif33[31:0] & m32;

  // Shifts: keep one extra bit to catch the last bit shifted out
  assign shl_t = {32'd0, d32} << cnt5;
  assign shr_u = {d32, 1'b0} >> cnt5;
  assign dsx64 = sext64(d32, i_size);
  assign dsx   = dsx64[32:0];
  assign sar_u = $signed({dsx, 1'b0}) >>> cnt5;

  // Signed operand magnitudes for the divider
  assign is_signed = (i_mode == OP_IDIV) || (i_mode == OP_IMOD);
  assign na = is_signed & i_dst[63];
  assign nb = is_signed & i_src[63];

  // One multiplier bit per step; the sign bit of imul weighs negative
  assign mul_add = opb_r[0] ? opa_r : 64'd0;

  // One restoring divide step
  assign div_t  = {acc_r, opa_r[63]};
  assign div_d  = div_t - {1'b0, opb_r};
  assign div_ge = !div_d[64];

  // Finish: mask the product, fix quotient and remainder signs
  always_comb begin
    case (size_r)
      SZ_8: begin
        prod    = {48'd0, acc_r[15:0]};
        prod_hi = acc_r[15:8] != 8'd0;
      end
      SZ_16: begin
        prod    = {32'd0, acc_r[31:0]};
        prod_hi = acc_r[31:16] != 16'd0;
      end
      default: begin
        prod    = acc_r;
        prod_hi = acc_r[63:32] != 32'd0;
      end
    endcase
  end

  assign quo = neg_q_r ? (64'd0 - opa_r) : opa_r;
  assign rmd = neg_m_r ? (64'd0 - acc_r) : acc_r;

  always_comb begin
    case (mode_r)
      OP_MUL, OP_IMUL:      fin_val = prod;
      OP_DIV, OP_IDIV:      fin_val = {32'd0, quo[31:0] & size_mask(size_r)};
      default:              fin_val = {32'd0, rmd[31:0] & size_mask(size_r)};
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    neg_q_nxt     = neg_q_r;
    neg_m_nxt     = neg_m_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    out_res_nxt   = out_res_r;
    flag_nxt      = flag_r;
    out_de_nxt    = out_de_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt      = i_mode;
          size_nxt      = i_size;
          out_de_nxt    = 1'b0;
          out_res_nxt   = 64'd0;
          out_valid_nxt = 1'b1;
          case (i_mode)
            OP_ADD, OP_ADC: begin
              out_res_nxt = {32'd0, add_r};
              flag_nxt    = make_flags(add_r, i_size, bit_at_n(sum33, i_size),
                                       msb_at(~(d32 ^ s32) & (d32 ^ add_r), i_size));
            end
            OP_SUB, OP_SBB: begin
              out_res_nxt = {32'd0, sub_r};
              flag_nxt    = make_flags(sub_r, i_size, bit_at_n(dif33, i_size),
                                       msb_at((d32 ^ s32) & (d32 ^ sub_r), i_size));
            end
            OP_MUL, OP_IMUL: begin
              // Load the multiplicand and multiplier shift registers
              out_valid_nxt = out_valid_r && !out_tready;
              acc_nxt   = 64'd0;
              opa_nxt   = (i_mode == OP_IMUL) ? sext64(d32, i_size) : {32'd0, d32};
              opb_nxt   = {32'd0, s32};
              cnt_nxt   = size_m1(i_size);
              state_nxt = S_RUN;
            end
            OP_DIV, OP_IDIV, OP_MOD, OP_IMOD: begin
              if (i_src == 64'd0) begin
                out_de_nxt = 1'b1;
              end else begin
                out_valid_nxt = out_valid_r && !out_tready;
                acc_nxt   = 64'd0;
                opa_nxt   = na ? (64'd0 - i_dst) : i_dst;
                opb_nxt   = nb ? (64'd0 - i_src) : i_src;
                neg_q_nxt = na ^ nb;
                neg_m_nxt = na;
                cnt_nxt   = 6'd63;
                state_nxt = S_RUN;
              end
            end
            OP_AND, OP_XOR, OP_OR: begin
              out_res_nxt = (i_mode == OP_AND) ? {32'd0, d32 & s32} :
                            (i_mode == OP_XOR) ? {32'd0, d32 ^ s32} : {32'd0, d32 | s32};
              flag_nxt    = make_flags(out_res_nxt[31:0], i_size, 1'b0, 1'b0);
            end
            OP_SHL, OP_SAL: begin
              if (cnt5 == 5'd0) begin
                out_res_nxt = {32'd0, d32};
              end else begin
                out_res_nxt = {32'd0, shl_t[31:0] & m32};
                flag_nxt    = make_flags(shl_t[31:0] & m32, i_size, bit_at_n(shl_t[32:0], i_size),
                                         msb_at(shl_t[31:0], i_size) ^ bit_at_n(shl_t[32:0], i_size));
              end
            end
            OP_SHR: begin
              if (cnt5 == 5'd0) begin
                out_res_nxt = {32'd0, d32};
              end else begin
                out_res_nxt = {32'd0, shr_u[32:1]};
                flag_nxt    = make_flags(shr_u[32:1], i_size, shr_u[0], msb_at(d32, i_size));
              end
            end
            OP_SAR: begin
              if (cnt5 == 5'd0) begin
                out_res_nxt = {32'd0, d32};
              end else begin
                out_res_nxt = {32'd0, sar_u[32:1] & m32};
                flag_nxt    = make_flags(sar_u[32:1] & m32, i_size, sar_u[0], 1'b0);
              end
            end
            default: out_res_nxt = 64'd0;
          endcase
        end
      end

      S_RUN: begin
        if ((mode_r == OP_MUL) || (mode_r == OP_IMUL)) begin
          // Shift-add; subtract on the sign bit for imul
          if ((cnt_r == 6'd0) && (mode_r == OP_IMUL)) acc_nxt = acc_r - mul_add;
          else                                        acc_nxt = acc_r + mul_add;
          opa_nxt = {opa_r[62:0], 1'b0};
          opb_nxt = {1'b0, opb_r[63:1]};
        end else begin
          // Shift-subtract, quotient bits enter at the bottom
          acc_nxt = div_ge ? div_d[63:0] : div_t[63:0];
          opa_nxt = {opa_r[62:0], div_ge};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hold until the output register is free
        if (out_free) begin
          out_res_nxt   = fin_val;
          out_valid_nxt = 1'b1;
          if (mode_r == OP_MUL) begin
            flag_nxt = make_flags(prod[31:0] & size_mask(size_r), size_r, prod_hi, prod_hi);
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      flag_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      flag_r      <= flag_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    mode_r    <= mode_nxt;
    size_r    <= size_nxt;
    neg_q_r   <= neg_q_nxt;
    neg_m_r   <= neg_m_nxt;
    acc_r     <= acc_nxt;
    opa_r     <= opa_nxt;
    opb_r     <= opb_nxt;
    out_res_r <= out_res_nxt;
    out_de_r  <= out_de_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_de_r, flag_r, out_res_r};

  // A zero divisor reports at once with the error bit
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (i_src == 64'd0) &&
     ((i_mode == OP_DIV) || (i_mode == OP_IDIV) || (i_mode == OP_MOD) || (i_mode == OP_IMOD)))
    |=> (out_valid_r && out_de_r))
    else $error("zero divisor did not report a divide error");

  // No new request while the serial unit works
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("request taken while busy");

  // Flags change only when the output register is loaded
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(flag_r))
    else $error("flags changed under a stalled result");

endmodule
`default_nettype wire
